// File: src/assert_macros.svh
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("same-cycle implication violated");

// Condition a implies condition b in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle implication violated");

`endif

// File: src/fdi_pkg.sv
// Types and constants for the decimal integer formatter.
package fdi_pkg;

	localparam int unsigned IN_WIDTH = 64;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	typedef struct packed {
		logic [IN_WIDTH-1:0] value;
		logic                is_signed;
	} in_item_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

// File: src/fdi_stream_if.sv
// Valid/ready stream interface carrying one payload item per transaction.
interface fdi_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/format_decimal_integer.sv
// Decimal ASCII formatter for one integer, using a shift-and-add-3 BCD converter.
// Sequence: accept the number, convert it one bit per cycle in the BCD shift loop,
// drop leading zero digits while keeping at least one, emit '-' for a negative input,
// then emit one character per dout transfer, stalling while dout is not ready. A new
// number is accepted only after the last character of the previous one has been sent.
// Reset: arst_n clears the sequencer to idle; the datapath registers are not reset.
`include "assert_macros.svh"

module format_decimal_integer #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	fdi_stream_if.sink         din,
	fdi_stream_if.source       dout
);

	// Decimal digits needed for 2^VALUE_WIDTH - 1.
	localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned BCDW = NDIG * 4;
	localparam int unsigned BW   = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned DW   = $clog2(NDIG + 1);

	fdi_pkg::state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCDW-1:0]        bcd_q;
	logic [BW-1:0]          bit_cnt_q;
	logic [DW-1:0]          dig_cnt_q;
	logic                   neg_q;

	logic [VALUE_WIDTH-1:0] in_v;
	logic                   in_neg;
	logic [BCDW-1:0]        bcd_adj;
	logic [3:0]             top_dig;
	logic                   in_fire;
	logic                   out_fire;
	logic                   last_dig;

	assign in_v     = din.data.value[VALUE_WIDTH-1:0];
	assign in_neg   = din.data.is_signed & in_v[VALUE_WIDTH-1];
	assign top_dig  = bcd_q[BCDW-1 -: 4];
	assign in_fire  = din.valid & din.ready;
	assign out_fire = dout.valid & dout.ready;
	assign last_dig = (dig_cnt_q == DW'(1));

	// Add 3 to every digit of 5 or more ahead of the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdi_pkg::ST_IDLE: begin
				if (in_fire) state_d = fdi_pkg::ST_CONVERT;
			end
			fdi_pkg::ST_CONVERT: begin
				if (bit_cnt_q == BW'(1)) state_d = fdi_pkg::ST_SKIP;
			end
			fdi_pkg::ST_SKIP: begin
				if (!(top_dig == 4'd0 && !last_dig)) begin
					state_d = neg_q ? fdi_pkg::ST_SIGN : fdi_pkg::ST_EMIT;
				end
			end
			fdi_pkg::ST_SIGN: begin
				if (out_fire) state_d = fdi_pkg::ST_EMIT;
			end
			fdi_pkg::ST_EMIT: begin
				if (out_fire && last_dig) state_d = fdi_pkg::ST_IDLE;
			end
			default: state_d = fdi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		din.ready            = 1'b0;
		dout.valid           = 1'b0;
		dout.data.character  = fdi_pkg::ASCII_ZERO + {4'd0, top_dig};
		dout.data.last       = last_dig;
		case (state_q)
			fdi_pkg::ST_IDLE: din.ready = 1'b1;
			fdi_pkg::ST_SIGN: begin
				dout.valid          = 1'b1;
				dout.data.character = fdi_pkg::ASCII_MINUS;
				dout.data.last      = 1'b0;
			end
			fdi_pkg::ST_EMIT: dout.valid = 1'b1;
			default: begin
				din.ready  = 1'b0;
				dout.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fdi_pkg::ST_IDLE: begin
				if (in_fire) begin
					mag_q     <= in_neg ? (~in_v + VALUE_WIDTH'(1)) : in_v;
					neg_q     <= in_neg;
					bcd_q     <= '0;
					bit_cnt_q <= BW'(VALUE_WIDTH);
					dig_cnt_q <= DW'(NDIG);
				end
			end
			fdi_pkg::ST_CONVERT: begin
				bcd_q     <= {bcd_adj[BCDW-2:0], mag_q[VALUE_WIDTH-1]};
				mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - BW'(1);
			end
			fdi_pkg::ST_SKIP: begin
				// Drop a leading zero, keeping at least one digit.
				if (top_dig == 4'd0 && !last_dig) begin
					bcd_q     <= {bcd_q[BCDW-5:0], 4'd0};
					dig_cnt_q <= dig_cnt_q - DW'(1);
				end
			end
			fdi_pkg::ST_EMIT: begin
				if (out_fire) begin
					bcd_q     <= {bcd_q[BCDW-5:0], 4'd0};
					dig_cnt_q <= dig_cnt_q - DW'(1);
				end
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	`ASSERT_IMPLY(a_no_overlap, clk, arst_n, dout.valid, !din.ready)
	`ASSERT_NEXT(a_accept_converts, clk, arst_n, in_fire, state_q == fdi_pkg::ST_CONVERT)
	`ASSERT_IMPLY(a_digit_left, clk, arst_n, state_q == fdi_pkg::ST_EMIT, dig_cnt_q != '0)
	`ASSERT_IMPLY(a_bcd_digit, clk, arst_n, state_q == fdi_pkg::ST_EMIT, top_dig <= 4'd9)

endmodule
